// ===== hw/rtl/mbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrf_pkg
// Shared constants and the CRC-16/MODBUS byte step for the RTU request framer.
// ----------------------------------------------------------------------------
package mbrf_pkg;

    // frame geometry
    localparam int unsigned FRAME_LEN   = 8;
    localparam int unsigned HDR_LEN     = 6;
    localparam int unsigned CNT_W       = $clog2(FRAME_LEN);

    // function codes
    localparam logic [7:0]  FC_READ     = 8'h03;
    localparam logic [7:0]  FC_WRITE    = 8'h06;

    // crc constants
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // register map
    localparam int unsigned PADDR_W     = 4;
    typedef enum logic [1:0] {
        REG_SLAVE_ADDRESS  = 2'd0,
        REG_WRITE_REGISTER = 2'd1,
        REG_READ_REGISTER  = 2'd2,
        REG_READ_COUNT     = 2'd3
    } reg_idx_t;

    localparam logic [7:0]  SLAVE_ADDRESS_RST  = 8'h01;
    localparam logic [15:0] WRITE_REGISTER_RST = 16'h002C;
    localparam logic [15:0] READ_REGISTER_RST  = 16'h0000;
    localparam logic [15:0] READ_COUNT_RST     = 16'h0001;

    // request kind
    localparam logic        KIND_READ   = 1'b0;
    localparam logic        KIND_WRITE  = 1'b1;

    // one byte of reflected crc, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int n = 0; n < 8; n++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/modbus_rtu_request_framer_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_unit
// Builds an 8-byte Modbus RTU request frame (read or write-single-register)
// with trailing CRC-16/MODBUS and streams it out one byte per cycle.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its frame passes
// through the CRC pipeline and the serializer onto tx_byte, one byte per cycle
// for eight consecutive bytes, each marked by tx_valid, with last set on the
// final CRC high byte. The receiver has no way to hold bytes off and must take
// each one as it comes. After an accepted request busy stays high until the
// gap counter runs down, a spacing set by the single byte-wide serializer. The
// CRC pipeline folds one header byte per stage after the first, so a request
// can sit in it while the frame before streams. Configuration must be written
// over the APB port only while no request is in flight; nothing enforces it.
module modbus_rtu_request_framer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // request side
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [7:0]                       value,
    // result side
    output logic                             tx_valid,
    output logic [7:0]                       tx_byte,
    output logic                             last,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mbrf_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int unsigned NSTG = mbrf_pkg::HDR_LEN + 1;

    // configuration registers
    logic [7:0]  slave_address_reg;
    logic [15:0] write_register_reg;
    logic [15:0] read_register_reg;
    logic [15:0] read_count_reg;
    logic        cfg_we;
    mbrf_pkg::reg_idx_t cfg_idx;

    // accept and spacing
    logic                            accept;
    logic [mbrf_pkg::CNT_W-1:0]      gap_reg;
    logic [mbrf_pkg::CNT_W-1:0]      gap_next;

    // crc pipeline
    logic        vld_reg   [NSTG];
    logic [47:0] frame_reg [NSTG];
    logic [15:0] crc_reg   [NSTG];
    logic [47:0] frame_in;
    logic [15:0] reg_addr;

    // output serializer
    logic [55:0]                     ser_reg;
    logic [55:0]                     ser_next;
    logic [mbrf_pkg::CNT_W-1:0]      rem_reg;
    logic [mbrf_pkg::CNT_W-1:0]      rem_next;
    logic                            tx_valid_reg;
    logic                            tx_valid_next;
    logic                            last_reg;
    logic                            last_next;
    logic [7:0]                      tx_byte_reg;
    logic [7:0]                      tx_byte_next;

    // apb decode
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = mbrf_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg  <= mbrf_pkg::SLAVE_ADDRESS_RST;
            write_register_reg <= mbrf_pkg::WRITE_REGISTER_RST;
            read_register_reg  <= mbrf_pkg::READ_REGISTER_RST;
            read_count_reg     <= mbrf_pkg::READ_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                mbrf_pkg::REG_SLAVE_ADDRESS:  slave_address_reg  <= pwdata[7:0];
                mbrf_pkg::REG_WRITE_REGISTER: write_register_reg <= pwdata[15:0];
                mbrf_pkg::REG_READ_REGISTER:  read_register_reg  <= pwdata[15:0];
                mbrf_pkg::REG_READ_COUNT:     read_count_reg     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (cfg_idx)
            mbrf_pkg::REG_SLAVE_ADDRESS:  prdata = {24'h0, slave_address_reg};
            mbrf_pkg::REG_WRITE_REGISTER: prdata = {16'h0, write_register_reg};
            mbrf_pkg::REG_READ_REGISTER:  prdata = {16'h0, read_register_reg};
            mbrf_pkg::REG_READ_COUNT:     prdata = {16'h0, read_count_reg};
            default:                      prdata = 32'h0;
        endcase
    end

    // accept only while not busy; the gap counter spaces accepted items
    assign accept = start & ~busy;
    assign busy   = (gap_reg != '0);

    always_comb
    begin
        if (accept)
            gap_next = mbrf_pkg::CNT_W'(mbrf_pkg::FRAME_LEN - 1);
        else if (gap_reg != '0)
            gap_next = gap_reg - 1'b1;
        else
            gap_next = gap_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= '0;
        else
            gap_reg <= gap_next;
    end

    // header bytes, byte 0 in the low bits
    always_comb
    begin
        reg_addr = (kind == mbrf_pkg::KIND_WRITE) ? write_register_reg : read_register_reg;
        frame_in[7:0]   = slave_address_reg;
        frame_in[15:8]  = (kind == mbrf_pkg::KIND_WRITE) ? mbrf_pkg::FC_WRITE
                                                        : mbrf_pkg::FC_READ;
        frame_in[23:16] = reg_addr[15:8];
        frame_in[31:24] = reg_addr[7:0];
        if (kind == mbrf_pkg::KIND_WRITE)
        begin
            frame_in[39:32] = 8'h00;
            frame_in[47:40] = value;
        end
        else
        begin
            frame_in[39:32] = read_count_reg[15:8];
            frame_in[47:40] = read_count_reg[7:0];
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTG; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int s = 1; s < NSTG; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // pipeline payload, stage s folds header byte s-1 into the crc
    always_ff @(posedge clk)
    begin
        frame_reg[0] <= frame_in;
        crc_reg[0]   <= mbrf_pkg::CRC_INIT;
        for (int s = 1; s < NSTG; s++)
        begin
            frame_reg[s] <= frame_reg[s-1];
            crc_reg[s]   <= mbrf_pkg::crc_byte(crc_reg[s-1], frame_reg[s-1][8*(s-1) +: 8]);
        end
    end

    // serializer: load a whole frame, then shift one byte per cycle
    always_comb
    begin
        ser_next      = ser_reg;
        rem_next      = rem_reg;
        tx_valid_next = 1'b0;
        last_next     = 1'b0;
        tx_byte_next  = tx_byte_reg;
        if (vld_reg[NSTG-1])
        begin
            tx_valid_next = 1'b1;
            tx_byte_next  = frame_reg[NSTG-1][7:0];
            ser_next      = {crc_reg[NSTG-1][15:8], crc_reg[NSTG-1][7:0],
                             frame_reg[NSTG-1][47:8]};
            rem_next      = mbrf_pkg::CNT_W'(mbrf_pkg::FRAME_LEN - 1);
        end
        else if (rem_reg != '0)
        begin
            tx_valid_next = 1'b1;
            tx_byte_next  = ser_reg[7:0];
            ser_next      = {8'h00, ser_reg[55:8]};
            rem_next      = rem_reg - 1'b1;
            last_next     = (rem_reg == mbrf_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg      <= '0;
            tx_valid_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            rem_reg      <= rem_next;
            tx_valid_reg <= tx_valid_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ser_reg     <= ser_next;
        tx_byte_reg <= tx_byte_next;
    end

    assign tx_valid = tx_valid_reg;
    assign tx_byte  = tx_byte_reg;
    assign last     = last_reg;

endmodule

// ===== hw/rtl/mbrf_checker.sv =====
// ----------------------------------------------------------------------------
// mbrf_checker
// Port-level checks on item spacing and frame streaming of the framer.
// ----------------------------------------------------------------------------
module mbrf_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic tx_valid,
    input logic last
);

    // an accepted item blocks the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted item");

    // last only marks a valid byte
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> tx_valid)
        else $error("last without tx_valid");

    // bytes of a frame come without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && !last) |=> tx_valid)
        else $error("gap inside a frame");

    // a frame is eight bytes long
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && last) |-> ($past(tx_valid, 7) && !$past(last, 1)))
        else $error("frame shorter than eight bytes");

endmodule

bind modbus_rtu_request_framer_unit mbrf_checker u_mbrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .tx_valid (tx_valid),
    .last     (last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Modbus RTU request framer: read and write requests are sent under
// several register settings and sender gap patterns, and each streamed frame
// byte is compared with a locally built frame including its CRC-16/MODBUS.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned RUN_LIMIT = 60000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // one frame byte as seen on the result ports
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    // holds the register copy and the frame bytes still to come
    class rtu_frame_checker;
        logic [7:0]  slave_addr;
        logic [15:0] wr_reg_addr;
        logic [15:0] rd_reg_addr;
        logic [15:0] rd_count;
        frame_byte_t pending_bytes[$];
        int          mismatches;

        function new();
            slave_addr  = mbrf_pkg::SLAVE_ADDRESS_RST;
            wr_reg_addr = mbrf_pkg::WRITE_REGISTER_RST;
            rd_reg_addr = mbrf_pkg::READ_REGISTER_RST;
            rd_count    = mbrf_pkg::READ_COUNT_RST;
            mismatches  = 0;
        endfunction

        function void set_register(mbrf_pkg::reg_idx_t idx, logic [31:0] data);
            case (idx)
                mbrf_pkg::REG_SLAVE_ADDRESS:  slave_addr  = data[7:0];
                mbrf_pkg::REG_WRITE_REGISTER: wr_reg_addr = data[15:0];
                mbrf_pkg::REG_READ_REGISTER:  rd_reg_addr = data[15:0];
                mbrf_pkg::REG_READ_COUNT:     rd_count    = data[15:0];
                default: ;
            endcase
        endfunction

        // bitwise reflected crc, lsb of each byte first
        function logic [15:0] crc_over(logic [7:0] bytes [6]);
            logic [15:0] crc;
            logic        fb;
            crc = mbrf_pkg::CRC_INIT;
            for (int i = 0; i < 6; i++)
            begin
                for (int b = 0; b < 8; b++)
                begin
                    fb  = crc[0] ^ bytes[i][b];
                    crc = {1'b0, crc[15:1]};
                    if (fb)
                        crc = crc ^ mbrf_pkg::CRC_POLY;
                end
            end
            return crc;
        endfunction

        // build the frame for one accepted request item
        function void note_request(logic req_kind, logic [7:0] req_value);
            logic [7:0]  hdr [6];
            logic [15:0] reg_addr;
            logic [15:0] crc;
            frame_byte_t fb;
            reg_addr = (req_kind == mbrf_pkg::KIND_WRITE) ? wr_reg_addr : rd_reg_addr;
            hdr[0] = slave_addr;
            hdr[1] = (req_kind == mbrf_pkg::KIND_WRITE) ? mbrf_pkg::FC_WRITE
                                                        : mbrf_pkg::FC_READ;
            hdr[2] = reg_addr[15:8];
            hdr[3] = reg_addr[7:0];
            hdr[4] = (req_kind == mbrf_pkg::KIND_WRITE) ? 8'h00 : rd_count[15:8];
            hdr[5] = (req_kind == mbrf_pkg::KIND_WRITE) ? req_value : rd_count[7:0];
            crc = crc_over(hdr);
            for (int i = 0; i < 6; i++)
            begin
                fb.data = hdr[i];
                fb.last = 1'b0;
                pending_bytes.push_back(fb);
            end
            fb.data = crc[7:0];
            fb.last = 1'b0;
            pending_bytes.push_back(fb);
            fb.data = crc[15:8];
            fb.last = 1'b1;
            pending_bytes.push_back(fb);
        endfunction

        function void check_byte(logic [7:0] got_data, logic got_last);
            frame_byte_t exp_byte;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got tx_byte=%02h last=%0b",
                         $time, got_data, got_last);
                mismatches++;
                return;
            end
            exp_byte = pending_bytes.pop_front();
            if (got_data !== exp_byte.data)
            begin
                $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                         $time, exp_byte.data, got_data);
                mismatches++;
            end
            if (got_last !== exp_byte.last)
            begin
                $display("%0t: last mismatch: expected %0b, got %0b",
                         $time, exp_byte.last, got_last);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          kind;
    logic [7:0]                    value;
    logic                          tx_valid;
    logic [7:0]                    tx_byte;
    logic                          last;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [mbrf_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    rtu_frame_checker    frames;
    int unsigned         cycle_count = 0;

    modbus_rtu_request_framer_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .value    (value),
        .tx_valid (tx_valid),
        .tx_byte  (tx_byte),
        .last     (last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // frame byte monitor
    always @(posedge clk)
    begin
        if (rst_n && tx_valid === 1'b1)
            frames.check_byte(tx_byte, last);
    end

    // send one request item; entered and left just after a falling edge
    task automatic send_request(input logic req_kind, input logic [7:0] req_value);
        start <= 1'b1;
        kind  <= req_kind;
        value <= req_value;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        frames.note_request(req_kind, req_value);
        @(negedge clk);
    endtask

    // sender gap with noise on the ignored fields
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        kind  <= 1'($urandom);
        value <= 8'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    task automatic write_register(input mbrf_pkg::reg_idx_t idx, input logic [31:0] data);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mbrf_pkg::PADDR_W'(int'(idx) * 4);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        frames.set_register(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every frame byte has come out, then a few quiet cycles
    task automatic wait_drained();
        start <= 1'b0;
        while (frames.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // program all four registers: 0 all low, 1 all high, 2 random
    task automatic program_registers(input int mode);
        logic [31:0] data;
        for (int r = 0; r < 4; r++)
        begin
            case (mode)
                0:       data = 32'h0000_0000;
                1:       data = 32'hFFFF_FFFF;
                default: data = $urandom;
            endcase
            write_register(mbrf_pkg::reg_idx_t'(r), data);
        end
    endtask

    initial
    begin
        int idle_pct [6];
        int cfg_mode [6];
        idle_pct = '{0, 56, 16, 0, 56, 16};
        cfg_mode = '{2, 1, 0, 2, 2, 1};
        frames      = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        kind    = mbrf_pkg::KIND_READ;
        value   = 8'h00;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = 32'h0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset settings, field extremes, read with a nonzero value to be ignored
        send_request(mbrf_pkg::KIND_READ, 8'h00);
        send_request(mbrf_pkg::KIND_WRITE, 8'h00);
        send_request(mbrf_pkg::KIND_WRITE, 8'hFF);
        send_request(mbrf_pkg::KIND_READ, 8'hFF);
        send_request(mbrf_pkg::KIND_WRITE, 8'h55);
        send_request(mbrf_pkg::KIND_WRITE, 8'hAA);
        wait_drained();

        // all-low registers
        program_registers(0);
        send_request(mbrf_pkg::KIND_READ, 8'hA5);
        send_request(mbrf_pkg::KIND_WRITE, 8'h00);
        send_request(mbrf_pkg::KIND_WRITE, 8'hFF);
        wait_drained();

        // all-high registers, upper data bits set and dropped
        program_registers(1);
        send_request(mbrf_pkg::KIND_READ, 8'h00);
        send_request(mbrf_pkg::KIND_WRITE, 8'h01);
        send_request(mbrf_pkg::KIND_WRITE, 8'h80);
        hold_off(3);
        send_request(mbrf_pkg::KIND_READ, 8'h7F);
        wait_drained();

        // random phases with varying sender gaps
        for (int p = 0; p < 6; p++)
        begin
            program_registers(cfg_mode[p]);
            for (int n = 0; n < 25; n++)
            begin
                if ($urandom_range(0, 99) < idle_pct[p])
                    hold_off($urandom_range(1, 12));
                send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (frames.mismatches == 0 && frames.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
